### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the go-to-goal controller RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define GGBC_AST_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define GGBC_AST_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/ggbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggbc_pkg
// Types, constants and tables shared by the go-to-goal controller modules.
// ----------------------------------------------------------------------------
package ggbc_pkg;

   // default build parameters
   localparam int unsigned GGBC_SPEED_FLOOR  = 0;
   localparam int unsigned GGBC_ACCEL_LIMIT  = 2048;
   localparam int unsigned GGBC_CORDIC_STEPS = 16;

   // angle constants, Q3.13 and Q2.30
   localparam logic signed [18:0] ANG_PI      = 19'sd25736;
   localparam logic signed [18:0] ANG_2PI     = 19'sd51472;
   localparam logic [14:0]        ANG_HALF_PI = 15'd12868;
   localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
   localparam logic signed [35:0] INV_GAIN    = 36'sd652032874;

   // serial multiplier and root widths
   localparam int unsigned MUL_AW  = 34;
   localparam int unsigned MUL_BW  = 32;
   localparam int unsigned SQRT_RW = 64;

   // configuration register indexes
   localparam logic [3:0] CSR_GAIN_LIN  = 4'd0;
   localparam logic [3:0] CSR_GAIN_ANG  = 4'd1;
   localparam logic [3:0] CSR_SPD_LIM   = 4'd2;
   localparam logic [3:0] CSR_TURN_LIM  = 4'd3;
   localparam logic [3:0] CSR_TURN_FLR  = 4'd4;
   localparam logic [3:0] CSR_ARRIVE    = 4'd5;
   localparam logic [3:0] CSR_HEAD_WIN  = 4'd6;
   localparam logic [3:0] CSR_ALIGN_WIN = 4'd7;

   // motion phases
   typedef enum logic [1:0] {
      PH_TURN  = 2'd0,
      PH_DRIVE = 2'd1,
      PH_ALIGN = 2'd2,
      PH_STOP  = 2'd3
   } phase_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE, ST_SQX, ST_SQY, ST_ROOT, ST_BEAR, ST_DECIDE, ST_TURN,
      ST_LIN, ST_COS, ST_SCALE, ST_BRKM, ST_BRKR, ST_DONE
   } state_type;

   // CORDIC command
   typedef struct packed {
      logic start;
      logic vectoring;
   } cordic_ctl_type;

   // arctangent of 2^-i, Q2.30
   function automatic logic [31:0] atan_q30(input logic [4:0] i);
      logic [31:0] r;
      unique case (i)
         5'd0:  r = 32'h3243F6A8;
         5'd1:  r = 32'h1DAC6705;
         5'd2:  r = 32'h0FADBAFC;
         5'd3:  r = 32'h07F56EA6;
         5'd4:  r = 32'h03FEAB76;
         5'd5:  r = 32'h01FFD55B;
         5'd6:  r = 32'h00FFFAAA;
         5'd7:  r = 32'h007FFF55;
         5'd8:  r = 32'h003FFFEA;
         5'd9:  r = 32'h001FFFFD;
         5'd10: r = 32'h000FFFFF;
         5'd11: r = 32'h0007FFFF;
         5'd12: r = 32'h0003FFFF;
         5'd13: r = 32'h0001FFFF;
         5'd14: r = 32'h0000FFFF;
         5'd15: r = 32'h00007FFF;
         5'd16: r = 32'h00003FFF;
         5'd17: r = 32'h00001FFF;
         5'd18: r = 32'h00000FFF;
         5'd19: r = 32'h000007FF;
         5'd20: r = 32'h000003FF;
         5'd21: r = 32'h000001FF;
         5'd22: r = 32'h000000FF;
         5'd23: r = 32'h0000007F;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

   // wrap an angle into [-pi, pi], two correction steps
   function automatic logic signed [18:0] wrap_ang(input logic signed [18:0] a);
      logic signed [18:0] r;
      r = a;
      if (r > ANG_PI) r = r - ANG_2PI;
      else if (r < -ANG_PI) r = r + ANG_2PI;
      if (r > ANG_PI) r = r - ANG_2PI;
      else if (r < -ANG_PI) r = r + ANG_2PI;
      return r;
   endfunction

endpackage

### rtl/ggbc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggbc_mul
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ggbc_mul
   import ggbc_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [MUL_AW-1:0]           op_a,
   input  logic [MUL_BW-1:0]           op_b,
   output logic [MUL_AW+MUL_BW-1:0]    product,
   output logic                        done
);

   localparam int unsigned CW = $clog2(MUL_BW);

   logic [MUL_AW-1:0] a_ff;
   logic [MUL_AW-1:0] hi_ff;
   logic [MUL_BW-1:0] lo_ff;
   logic [CW-1:0]     cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [MUL_AW:0]   sum;

   // add the multiplicand when the current low bit is set
   assign sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(MUL_BW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // partial product shift register
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff  <= op_a;
         hi_ff <= '0;
         lo_ff <= op_b;
      end else if (busy_ff) begin
         hi_ff <= sum[MUL_AW:1];
         lo_ff <= {sum[0], lo_ff[MUL_BW-1:1]};
      end
   end

   assign product = {hi_ff, lo_ff};
   assign done    = done_ff;

endmodule

### rtl/ggbc_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggbc_sqrt
// Restoring integer square root, one root bit (two radicand bits) per cycle.
// ----------------------------------------------------------------------------
module ggbc_sqrt
   import ggbc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [SQRT_RW-1:0]     radicand,
   output logic [SQRT_RW/2-1:0]   root,
   output logic                   done
);

   localparam int unsigned QW = SQRT_RW / 2;
   localparam int unsigned CW = $clog2(QW);

   logic [SQRT_RW-1:0] rad_ff;
   logic [QW-1:0]      root_ff;
   logic [QW+1:0]      rem_ff;
   logic [CW-1:0]      cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [QW+3:0]      rem_t;
   logic [QW+3:0]      trial;
   logic [QW+3:0]      diff;
   logic               fits;

   // trial subtraction of 4*root+1
   assign rem_t = {rem_ff, rad_ff[SQRT_RW-1 -: 2]};
   assign trial = {2'b00, root_ff, 2'b01};
   assign diff  = rem_t - trial;
   assign fits  = (rem_t >= trial);

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(QW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // remainder and root registers
   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         root_ff <= '0;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[SQRT_RW-3:0], 2'b00};
         root_ff <= {root_ff[QW-2:0], fits};
         rem_ff  <= fits ? diff[QW+1:0] : rem_t[QW+1:0];
      end
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

### rtl/ggbc_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggbc_cordic
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
// ----------------------------------------------------------------------------
module ggbc_cordic
   import ggbc_pkg::*;
#(
   parameter int unsigned STEPS = GGBC_CORDIC_STEPS
)(
   input  logic                clock,
   input  logic                reset,
   input  cordic_ctl_type      ctl,
   input  logic signed [35:0]  x_init,
   input  logic signed [35:0]  y_init,
   input  logic signed [33:0]  z_init,
   output logic signed [35:0]  x_out,
   output logic signed [33:0]  z_out,
   output logic                done
);

   localparam int unsigned CW = $clog2(STEPS);

   logic signed [35:0] x_ff;
   logic signed [35:0] y_ff;
   logic signed [33:0] z_ff;
   logic               vec_ff;
   logic [CW-1:0]      cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic signed [35:0] xs;
   logic signed [35:0] ys;
   logic signed [33:0] at;
   logic               sel;

   // shifted terms and direction
   assign xs  = x_ff >>> cnt_ff;
   assign ys  = y_ff >>> cnt_ff;
   assign at  = $signed({2'b00, atan_q30(5'(cnt_ff))});
   assign sel = vec_ff ? (y_ff > 36'sd0) : z_ff[33];

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // micro-rotation
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         x_ff   <= x_init;
         y_ff   <= y_init;
         z_ff   <= z_init;
         vec_ff <= ctl.vectoring;
      end else if (busy_ff) begin
         if (sel) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + at;
         end else begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - at;
         end
      end
   end

   assign x_out = x_ff;
   assign z_out = z_ff;
   assign done  = done_ff;

endmodule

### rtl/go_to_goal_base_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_to_goal_base_controller
// Differential-drive go-to-goal controller: goal load and pose control steps.
// ----------------------------------------------------------------------------
// Channel  Dir  Content
// req_     in   tdata: pos_x, pos_y, heading; tuser: op (1 = load goal)
// rsp_     out  tdata: linear_speed, turn_rate, phase_code
// csr_     in   index and data of a register write, always ready
//
// A goal load is registered when accepted and returns nothing. A control step
// runs the shared units in turn: two serial squares, a root and a CORDIC
// bearing. Turn and align commands then add a turn product; stopped and
// align-reached steps return without it. Drive results further add three
// serial products, a root and a cosine.
// Reset is synchronous; a finished result waits in the output register while
// the next item is accepted, and the sequencer stalls only if it is still full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module go_to_goal_base_controller
   import ggbc_pkg::*;
#(
   parameter int unsigned SPEED_FLOOR  = GGBC_SPEED_FLOOR,
   parameter int unsigned ACCEL_LIMIT  = GGBC_ACCEL_LIMIT,
   parameter int unsigned CORDIC_STEPS = GGBC_CORDIC_STEPS
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // pos_x[31:0], pos_y[63:32], heading[79:64]
   input  logic [0:0]  req_tuser,   // op[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // linear_speed[14:0], turn_rate[30:15],
                                    // phase_code[32:31], zero[39:33]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam logic [14:0] SPD_FLR = 15'(SPEED_FLOOR);
   localparam logic [15:0] ACC2    = 16'(2 * ACCEL_LIMIT);

   // configuration registers
   logic [15:0] gain_lin_ff, gain_ang_ff;
   logic [14:0] spd_lim_ff, turn_lim_ff, turn_flr_ff, head_win_ff, align_win_ff;
   logic [30:0] arrive_ff;

   // state and datapath registers
   state_type          state_ff, state_in;
   phase_type          phase_ff;
   logic               start_ff;
   logic signed [31:0] goal_x_ff, goal_y_ff;
   logic signed [15:0] goal_h_ff, hd_ff;
   logic signed [32:0] dx_ff, dy_ff;
   logic [30:0]        sx_ff, sy_ff;
   logic               big_ff, zero_vec_ff;
   logic [63:0]        sq_ff;
   logic [33:0]        rho_ff;
   logic signed [17:0] bearing_ff;
   logic signed [15:0] err_ff, theta_ff;
   logic               floor_ff, drive_ff, nocmd_ff;
   logic [14:0]        v_ff;
   logic [15:0]        cos_ff;
   logic signed [15:0] w_ff;
   logic               rsp_valid_ff;
   logic [39:0]        rsp_data_ff;

   // unit interfaces
   logic                       mul_start, mul_done, sqrt_start, sqrt_done, cor_done;
   logic [MUL_AW-1:0]          mul_a;
   logic [MUL_BW-1:0]          mul_b;
   logic [MUL_AW+MUL_BW-1:0]   mul_p;
   logic [SQRT_RW/2-1:0]       root;
   cordic_ctl_type             cor_ctl;
   logic signed [35:0]         cor_xi, cor_yi, cor_x;
   logic signed [33:0]         cor_zi, cor_z;

   // input unpacking
   logic               req_acc, req_op;
   logic signed [31:0] in_x, in_y;
   logic signed [15:0] in_h;
   logic signed [32:0] dx_in, dy_in;
   logic [32:0]        ax_in, ay_in;
   logic               big_in;

   assign req_acc = req_tvalid && req_tready;
   assign req_op  = req_tuser[0];
   assign in_x    = $signed(req_tdata[31:0]);
   assign in_y    = $signed(req_tdata[63:32]);
   assign in_h    = $signed(req_tdata[79:64]);
   assign dx_in   = {goal_x_ff[31], goal_x_ff} - {in_x[31], in_x};
   assign dy_in   = {goal_y_ff[31], goal_y_ff} - {in_y[31], in_y};
   assign ax_in   = dx_in[32] ? 33'(-dx_in) : 33'(dx_in);
   assign ay_in   = dy_in[32] ? 33'(-dy_in) : 33'(dy_in);
   assign big_in  = ax_in[32] | ax_in[31] | ay_in[32] | ay_in[31];

   // angle errors
   logic signed [18:0] theta_w, yaw_w;
   logic signed [15:0] theta, yaw;
   logic [14:0]        ath, ayaw;

   assign theta_w = wrap_ang({bearing_ff[17], bearing_ff} - {{3{hd_ff[15]}}, hd_ff});
   assign yaw_w   = wrap_ang({{3{goal_h_ff[15]}}, goal_h_ff} - {{3{hd_ff[15]}}, hd_ff});
   assign theta   = theta_w[15:0];
   assign yaw     = yaw_w[15:0];
   assign ath     = theta[15] ? 15'(-theta) : theta[14:0];
   assign ayaw    = yaw[15] ? 15'(-yaw) : yaw[14:0];

   // phase decision
   phase_type          ph_nx;
   logic               sel_yaw, fl_nx, dr_nx, nocmd_nx, near;

   assign near = (rho_ff <= {3'b000, arrive_ff});

   always_comb begin
      ph_nx    = phase_ff;
      sel_yaw  = 1'b0;
      fl_nx    = 1'b1;
      dr_nx    = 1'b0;
      nocmd_nx = 1'b0;
      unique case (phase_ff)
         PH_TURN: begin
            if (near) begin
               ph_nx   = PH_ALIGN;
               sel_yaw = 1'b1;
            end else if (ath <= head_win_ff) begin
               ph_nx = PH_DRIVE;
               fl_nx = 1'b0;
               dr_nx = 1'b1;
            end
         end
         PH_DRIVE: begin
            if (near) begin
               ph_nx   = PH_ALIGN;
               sel_yaw = 1'b1;
            end else if ({1'b0, ath} > {head_win_ff, 1'b0}) begin
               ph_nx = PH_TURN;
            end else begin
               fl_nx = 1'b0;
               dr_nx = 1'b1;
            end
         end
         PH_ALIGN: begin
            sel_yaw = 1'b1;
            if (ayaw <= align_win_ff) begin
               ph_nx    = PH_STOP;
               nocmd_nx = 1'b1;
            end
         end
         PH_STOP: begin
            nocmd_nx = 1'b1;
         end
         default: nocmd_nx = 1'b1;
      endcase
   end

   // turn command from the serial product
   logic [14:0]  aerr, tmag_cap, tmag;
   logic [21:0]  tmag_raw;
   assign aerr     = err_ff[15] ? 15'(-err_ff) : err_ff[14:0];
   assign tmag_raw = mul_p[30:9];
   assign tmag_cap = (tmag_raw > {7'd0, turn_lim_ff}) ? turn_lim_ff : tmag_raw[14:0];
   assign tmag     = (floor_ff && tmag_cap != 15'd0 && tmag_cap < turn_flr_ff) ?
                     turn_flr_ff : tmag_cap;

   // linear speed limit stage
   logic [37:0] vraw, vfl;
   logic [14:0] vlim;
   assign vraw = mul_p[49:12];
   assign vfl  = (vraw < {23'd0, SPD_FLR}) ? {23'd0, SPD_FLR} : vraw;
   assign vlim = (vfl > {23'd0, spd_lim_ff}) ? spd_lim_ff : vfl[14:0];

   // cosine from the rotation result
   logic signed [35:0] xsh;
   logic [15:0]        cos_v;
   assign xsh   = cor_x >>> 15;
   always_comb begin
      if ((theta_ff[15] ? 15'(-theta_ff) : theta_ff[14:0]) >= ANG_HALF_PI) cos_v = 16'd0;
      else if (xsh < 36'sd0) cos_v = 16'd0;
      else if (xsh > 36'sd32768) cos_v = 16'd32768;
      else cos_v = xsh[15:0];
   end

   // braking distance and bearing rounding
   logic [33:0] brk_dist;
   logic [34:0] zr;
   logic [29:0] vbrk;
   assign brk_dist = (rho_ff > {3'b000, arrive_ff}) ? rho_ff - {3'b000, arrive_ff} : 34'd0;
   assign zr       = {cor_z[33], cor_z} + 35'sd65536;
   assign vbrk     = root[31:2];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_acc && !req_op) state_in = ST_SQX;
         ST_SQX:    if (mul_done) state_in = ST_SQY;
         ST_SQY:    if (mul_done) state_in = ST_ROOT;
         ST_ROOT:   if (sqrt_done) state_in = ST_BEAR;
         ST_BEAR:   if (cor_done) state_in = ST_DECIDE;
         ST_DECIDE: state_in = nocmd_nx ? ST_DONE : ST_TURN;
         ST_TURN:   if (mul_done) state_in = drive_ff ? ST_LIN : ST_DONE;
         ST_LIN:    if (mul_done) state_in = ST_COS;
         ST_COS:    if (cor_done) state_in = ST_SCALE;
         ST_SCALE:  if (mul_done) state_in = ST_BRKM;
         ST_BRKM:   if (mul_done) state_in = ST_BRKR;
         ST_BRKR:   if (sqrt_done) state_in = ST_DONE;
         ST_DONE:   if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // unit launch and operand selection
   always_comb begin
      req_tready        = (state_ff == ST_IDLE);
      mul_start         = 1'b0;
      sqrt_start        = 1'b0;
      cor_ctl.start     = 1'b0;
      cor_ctl.vectoring = 1'b0;
      mul_a             = '0;
      mul_b             = '0;
      cor_xi            = INV_GAIN;
      cor_yi            = '0;
      cor_zi            = {theta_ff[15], theta_ff, 17'd0};
      unique case (state_ff)
         ST_SQX: begin
            mul_start = start_ff;
            mul_a     = {3'b000, sx_ff};
            mul_b     = {1'b0, sx_ff};
         end
         ST_SQY: begin
            mul_start = start_ff;
            mul_a     = {3'b000, sy_ff};
            mul_b     = {1'b0, sy_ff};
         end
         ST_ROOT, ST_BRKR: sqrt_start = start_ff;
         ST_BEAR: begin
            cor_ctl.start     = start_ff;
            cor_ctl.vectoring = 1'b1;
            cor_xi = dx_ff[32] ? -{{3{dx_ff[32]}}, dx_ff} : {{3{dx_ff[32]}}, dx_ff};
            cor_yi = dx_ff[32] ? -{{3{dy_ff[32]}}, dy_ff} : {{3{dy_ff[32]}}, dy_ff};
            cor_zi = dx_ff[32] ? (dy_ff[32] ? -Q30_PI : Q30_PI) : 34'sd0;
         end
         ST_TURN: begin
            mul_start = start_ff;
            mul_a     = {19'd0, aerr};
            mul_b     = {16'd0, gain_ang_ff};
         end
         ST_LIN: begin
            mul_start = start_ff;
            mul_a     = rho_ff;
            mul_b     = {16'd0, gain_lin_ff};
         end
         ST_COS: cor_ctl.start = start_ff;
         ST_SCALE: begin
            mul_start = start_ff;
            mul_a     = {19'd0, v_ff};
            mul_b     = {16'd0, cos_ff};
         end
         ST_BRKM: begin
            mul_start = start_ff;
            mul_a     = brk_dist;
            mul_b     = {16'd0, ACC2};
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         phase_ff     <= PH_STOP;
         rsp_valid_ff <= 1'b0;
         goal_x_ff    <= '0;
         goal_y_ff    <= '0;
         goal_h_ff    <= '0;
         gain_lin_ff  <= 16'd256;
         gain_ang_ff  <= 16'd512;
         spd_lim_ff   <= 15'd2048;
         turn_lim_ff  <= 15'd4096;
         turn_flr_ff  <= 15'd410;
         arrive_ff    <= 31'd3277;
         head_win_ff  <= 15'd819;
         align_win_ff <= 15'd410;
      end else begin
         state_ff <= state_in;
         start_ff <= (state_in != state_ff) && (state_in != ST_IDLE) &&
                     (state_in != ST_DECIDE) && (state_in != ST_DONE);
         // goal load
         if (req_acc && req_op) begin
            goal_x_ff <= in_x;
            goal_y_ff <= in_y;
            goal_h_ff <= in_h;
            phase_ff  <= PH_TURN;
         end
         if (state_ff == ST_DECIDE) phase_ff <= ph_nx;
         // result register
         if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         // register writes
         if (csr_valid) begin
            unique case (csr_index)
               CSR_GAIN_LIN:  gain_lin_ff  <= csr_data[15:0];
               CSR_GAIN_ANG:  gain_ang_ff  <= csr_data[15:0];
               CSR_SPD_LIM:   spd_lim_ff   <= csr_data[14:0];
               CSR_TURN_LIM:  turn_lim_ff  <= csr_data[14:0];
               CSR_TURN_FLR:  turn_flr_ff  <= csr_data[14:0];
               CSR_ARRIVE:    arrive_ff    <= csr_data[30:0];
               CSR_HEAD_WIN:  head_win_ff  <= csr_data[14:0];
               CSR_ALIGN_WIN: align_win_ff <= csr_data[14:0];
               default: begin
               end
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_acc && !req_op) begin
         hd_ff       <= in_h;
         dx_ff       <= dx_in;
         dy_ff       <= dy_in;
         big_ff      <= big_in;
         sx_ff       <= big_in ? ax_in[32:2] : ax_in[30:0];
         sy_ff       <= big_in ? ay_in[32:2] : ay_in[30:0];
         zero_vec_ff <= (dx_in == 33'sd0) && (dy_in == 33'sd0);
      end
      unique case (state_ff)
         ST_SQX:  if (mul_done) sq_ff <= mul_p[63:0];
         ST_SQY:  if (mul_done) sq_ff <= sq_ff + mul_p[63:0];
         ST_ROOT: if (sqrt_done) rho_ff <= big_ff ? {root, 2'b00} : {2'b00, root};
         ST_BEAR: if (cor_done) bearing_ff <= zero_vec_ff ? 18'sd0 : $signed(zr[34:17]);
         ST_DECIDE: begin
            err_ff   <= sel_yaw ? yaw : theta;
            theta_ff <= theta;
            floor_ff <= fl_nx;
            drive_ff <= dr_nx;
            nocmd_ff <= nocmd_nx;
            v_ff     <= '0;
            w_ff     <= '0;
         end
         ST_TURN:  if (mul_done) w_ff <= err_ff[15] ? -$signed({1'b0, tmag})
                                                    : $signed({1'b0, tmag});
         ST_LIN:   if (mul_done) v_ff <= vlim;
         ST_COS:   if (cor_done) cos_ff <= cos_v;
         ST_SCALE: if (mul_done) v_ff <= mul_p[29:15];
         ST_BRKM:  if (mul_done) sq_ff <= mul_p[63:0];
         ST_BRKR:  if (sqrt_done && vbrk < {15'd0, v_ff}) v_ff <= vbrk[14:0];
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_ff <= nocmd_ff ? {7'd0, phase_ff, 16'd0, 15'd0}
                                       : {7'd0, phase_ff, w_ff, v_ff};
            end
         end
         default: begin
         end
      endcase
   end

   // shared arithmetic units
   ggbc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p),
      .done    (mul_done)
   );

   ggbc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sq_ff),
      .root     (root),
      .done     (sqrt_done)
   );

   ggbc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .ctl    (cor_ctl),
      .x_init (cor_xi),
      .y_init (cor_yi),
      .z_init (cor_zi),
      .x_out  (cor_x),
      .z_out  (cor_z),
      .done   (cor_done)
   );

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   `GGBC_AST_IMP(a_stop_quiet, clock, reset,
      rsp_valid_ff && rsp_data_ff[32:31] == PH_STOP, rsp_data_ff[30:0] == 31'd0,
      "stopped result carries a command")
   `GGBC_AST_IMP(a_speed_drive, clock, reset,
      rsp_valid_ff && rsp_data_ff[32:31] != PH_DRIVE, rsp_data_ff[14:0] == 15'd0,
      "speed outside drive phase")
   `GGBC_AST_NXT(a_goal_turn, clock, reset, req_acc && req_op, phase_ff == PH_TURN,
      "goal load did not restart turn phase")

endmodule
